// ===== hdl/bps_pkg.sv =====
// Shared types and constants for the board power sequencer.
package bps_pkg;

	localparam int unsigned MsW = 16;
	localparam int unsigned CfgIdxW = 3;

	// Register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PRESS      = 3'd0,
		CFG_PRE_PRESS  = 3'd1,
		CFG_SETTLE     = 3'd2,
		CFG_PWROK_HOLD = 3'd3,
		CFG_BOOT_HOLD  = 3'd4,
		CFG_OFF_HOLD   = 3'd5,
		CFG_RESET_OFF  = 3'd6,
		CFG_MON_PERIOD = 3'd7
	} cfg_idx_t;

	localparam logic [MsW-1:0] PressMsRst      = 16'd200;
	localparam logic [MsW-1:0] PrePressMsRst   = 16'd500;
	localparam logic [MsW-1:0] SettleMsRst     = 16'd100;
	localparam logic [MsW-1:0] PwrokHoldMsRst  = 16'd500;
	localparam logic [MsW-1:0] BootHoldMsRst   = 16'd7000;
	localparam logic [MsW-1:0] OffHoldMsRst    = 16'd300;
	localparam logic [MsW-1:0] ResetOffMsRst   = 16'd5000;
	localparam logic [MsW-1:0] MonPeriodMsRst  = 16'd1000;

	// Command codes carried in the low two bits of a received byte
	typedef enum logic [1:0] {
		CMD_OFF    = 2'd0,
		CMD_ON     = 2'd1,
		CMD_NONE   = 2'd2,
		CMD_HARD_R = 2'd3
	} cmd_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_BYTE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [MsW-1:0] press_ms;
		logic [MsW-1:0] pre_press_ms;
		logic [MsW-1:0] settle_ms;
		logic [MsW-1:0] pwrok_hold_ms;
		logic [MsW-1:0] boot_hold_ms;
		logic [MsW-1:0] off_hold_ms;
		logic [MsW-1:0] reset_off_ms;
		logic [MsW-1:0] monitor_period_ms;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
		logic       status_led;
		logic       pson_level;
	} in_item_t;

	typedef struct packed {
		logic button_level;
		logic key_level;
		logic pwrok_level;
		logic adapter_on;
		logic busy_res;
	} out_item_t;

endpackage

// ===== hdl/bps_cfg_regs.sv =====
// Timing configuration registers of the power sequencer.
module bps_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [bps_pkg::CfgIdxW-1:0]  index,
	input  logic [bps_pkg::MsW-1:0]      data,
	output bps_pkg::cfg_t                cfg
);

	bps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ms          <= bps_pkg::PressMsRst;
			cfg_q.pre_press_ms      <= bps_pkg::PrePressMsRst;
			cfg_q.settle_ms         <= bps_pkg::SettleMsRst;
			cfg_q.pwrok_hold_ms     <= bps_pkg::PwrokHoldMsRst;
			cfg_q.boot_hold_ms      <= bps_pkg::BootHoldMsRst;
			cfg_q.off_hold_ms       <= bps_pkg::OffHoldMsRst;
			cfg_q.reset_off_ms      <= bps_pkg::ResetOffMsRst;
			cfg_q.monitor_period_ms <= bps_pkg::MonPeriodMsRst;
		end else if (we) begin
			case (bps_pkg::cfg_idx_t'(index))
				bps_pkg::CFG_PRESS:      cfg_q.press_ms          <= data;
				bps_pkg::CFG_PRE_PRESS:  cfg_q.pre_press_ms      <= data;
				bps_pkg::CFG_SETTLE:     cfg_q.settle_ms         <= data;
				bps_pkg::CFG_PWROK_HOLD: cfg_q.pwrok_hold_ms     <= data;
				bps_pkg::CFG_BOOT_HOLD:  cfg_q.boot_hold_ms      <= data;
				bps_pkg::CFG_OFF_HOLD:   cfg_q.off_hold_ms       <= data;
				bps_pkg::CFG_RESET_OFF:  cfg_q.reset_off_ms      <= data;
				bps_pkg::CFG_MON_PERIOD: cfg_q.monitor_period_ms <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/bps_seq_core.sv =====
// Sequencer state machine: one tick or byte per step, next levels out.
module bps_seq_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  bps_pkg::in_item_t    item,
	input  bps_pkg::cfg_t        cfg,
	output bps_pkg::out_item_t   nxt,
	output logic                 busy
);

	typedef enum logic [4:0] {
		ST_IDLE         = 5'd0,
		ST_OFF_WAIT_LOW = 5'd1,
		ST_OFF_HOLD     = 5'd2,
		ST_ON_PRE       = 5'd3,
		ST_ON_PRESS     = 5'd4,
		ST_ON_WAIT_HIGH = 5'd5,
		ST_ON_SETTLE    = 5'd6,
		ST_PWROK_HOLD   = 5'd7,
		ST_BOOT_HOLD    = 5'd8,
		ST_HR_WAIT_LOW  = 5'd9,
		ST_HR_OFF       = 5'd10,
		ST_HR_PRE       = 5'd11,
		ST_HR_PRESS     = 5'd12,
		ST_HR_WAIT_HIGH = 5'd13,
		ST_MON_UP       = 5'd14,
		ST_MON_DOWN     = 5'd15
	} step_t;

	step_t                   step_q, step_d;
	logic [bps_pkg::MsW-1:0] wait_q, wait_d, wait_dec;
	logic [bps_pkg::MsW-1:0] mon_q, mon_d, mon_inc, period;
	logic                    adapter_q, adapter_d;
	logic                    button_q, button_d;
	logic                    key_q, key_d;
	logic                    pwrok_q, pwrok_d;
	logic                    done;
	logic                    pson;
	bps_pkg::cmd_t           cmd;

	// Wait counters saturate at zero; a zero wait ends on the first tick.
	assign wait_dec = (wait_q != '0) ? wait_q - bps_pkg::MsW'(1) : '0;
	assign done     = (wait_dec == '0);
	assign mon_inc  = mon_q + bps_pkg::MsW'(1);
	assign period   = (cfg.monitor_period_ms == '0) ? bps_pkg::MsW'(1) : cfg.monitor_period_ms;
	assign pson     = item.pson_level;
	assign cmd      = bps_pkg::cmd_t'(item.rx_byte[1:0]);

	always_comb begin
		step_d    = step_q;
		wait_d    = wait_q;
		mon_d     = mon_q;
		adapter_d = adapter_q;
		button_d  = button_q;
		key_d     = key_q;
		pwrok_d   = pwrok_q;
		if (item.kind == bps_pkg::KIND_BYTE) begin
			if (step_q == ST_IDLE && item.status_led) begin
				case (cmd)
					bps_pkg::CMD_OFF: begin
						if (pson) begin
							button_d = 1'b0;
							step_d   = ST_OFF_WAIT_LOW;
						end
					end
					bps_pkg::CMD_ON: begin
						step_d = ST_ON_PRE;
						wait_d = cfg.pre_press_ms;
					end
					bps_pkg::CMD_HARD_R: begin
						if (pson) begin
							button_d = 1'b0;
							step_d   = ST_HR_WAIT_LOW;
						end
					end
					default: ;
				endcase
			end
		end else begin
			case (step_q)
				ST_IDLE: begin
					if (mon_inc < period) begin
						mon_d = mon_inc;
					end else begin
						mon_d = '0;
						if (pson && !adapter_q) begin
							key_d  = 1'b0;
							step_d = ST_MON_UP;
							wait_d = cfg.settle_ms;
						end else if (!pson && adapter_q) begin
							key_d  = 1'b1;
							step_d = ST_MON_DOWN;
							wait_d = cfg.settle_ms;
						end
					end
				end
				ST_OFF_WAIT_LOW: begin
					if (!pson) begin
						button_d = 1'b1;
						key_d    = 1'b1;
						pwrok_d  = 1'b1;
						step_d   = ST_OFF_HOLD;
						wait_d   = cfg.off_hold_ms;
					end
				end
				ST_OFF_HOLD: begin
					wait_d = wait_dec;
					if (done) begin
						adapter_d = 1'b0;
						step_d    = ST_IDLE;
					end
				end
				ST_ON_PRE: begin
					wait_d = wait_dec;
					if (done) begin
						button_d = 1'b0;
						step_d   = ST_ON_PRESS;
						wait_d   = cfg.press_ms;
					end
				end
				ST_ON_PRESS: begin
					wait_d = wait_dec;
					if (done) begin
						button_d = 1'b1;
						step_d   = ST_ON_WAIT_HIGH;
					end
				end
				ST_ON_WAIT_HIGH: begin
					if (pson) begin
						step_d = ST_ON_SETTLE;
						wait_d = cfg.settle_ms;
					end
				end
				ST_ON_SETTLE: begin
					wait_d = wait_dec;
					if (done) begin
						key_d   = 1'b0;
						pwrok_d = 1'b0;
						step_d  = ST_PWROK_HOLD;
						wait_d  = cfg.pwrok_hold_ms;
					end
				end
				ST_PWROK_HOLD: begin
					wait_d = wait_dec;
					if (done) begin
						adapter_d = 1'b1;
						step_d    = ST_BOOT_HOLD;
						wait_d    = cfg.boot_hold_ms;
					end
				end
				ST_BOOT_HOLD: begin
					wait_d = wait_dec;
					if (done) begin
						step_d = ST_IDLE;
					end
				end
				ST_HR_WAIT_LOW: begin
					if (!pson) begin
						button_d = 1'b1;
						pwrok_d  = 1'b1;
						key_d    = 1'b1;
						step_d   = ST_HR_OFF;
						wait_d   = cfg.reset_off_ms;
					end
				end
				ST_HR_OFF: begin
					wait_d = wait_dec;
					if (done) begin
						key_d  = 1'b0;
						step_d = ST_HR_PRE;
						wait_d = cfg.pre_press_ms;
					end
				end
				ST_HR_PRE: begin
					wait_d = wait_dec;
					if (done) begin
						button_d = 1'b0;
						step_d   = ST_HR_PRESS;
						wait_d   = cfg.press_ms;
					end
				end
				ST_HR_PRESS: begin
					wait_d = wait_dec;
					if (done) begin
						button_d = 1'b1;
						step_d   = ST_HR_WAIT_HIGH;
					end
				end
				ST_HR_WAIT_HIGH: begin
					if (pson) begin
						pwrok_d = 1'b0;
						step_d  = ST_PWROK_HOLD;
						wait_d  = cfg.pwrok_hold_ms;
					end
				end
				ST_MON_UP: begin
					wait_d = wait_dec;
					if (done) begin
						pwrok_d   = 1'b0;
						adapter_d = 1'b1;
						step_d    = ST_IDLE;
					end
				end
				ST_MON_DOWN: begin
					wait_d = wait_dec;
					if (done) begin
						pwrok_d   = 1'b1;
						adapter_d = 1'b0;
						step_d    = ST_IDLE;
					end
				end
				default: begin
					step_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_IDLE;
			wait_q    <= '0;
			mon_q     <= '0;
			adapter_q <= 1'b0;
			button_q  <= 1'b1;
			key_q     <= 1'b1;
			pwrok_q   <= 1'b1;
		end else if (step_en) begin
			step_q    <= step_d;
			wait_q    <= wait_d;
			mon_q     <= mon_d;
			adapter_q <= adapter_d;
			button_q  <= button_d;
			key_q     <= key_d;
			pwrok_q   <= pwrok_d;
		end
	end

	always_comb begin
		nxt.button_level = button_d;
		nxt.key_level    = key_d;
		nxt.pwrok_level  = pwrok_d;
		nxt.adapter_on   = adapter_d;
		nxt.busy_res     = (step_d != ST_IDLE);
	end

	assign busy = (step_q != ST_IDLE);

endmodule

// ===== hdl/board_power_sequencer.sv =====
// Board power sequencer top level: input stage, sequencer, result register.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------
//  item     | item_valid / item_ready     | item_data   (in_item_t)
//  result   | result_valid / result_ready | result_data (out_item_t)
//  config   | cfg_we (no wait)            | cfg_index, cfg_data
//
// Each beat is registered in the input stage, stepped through the sequencer
// and lands in the result register; one item per cycle is sustained while
// result_ready stays high. The single state update per cycle sets that rate.
// Reset puts the sequencer idle with button released, keys closed,
// power-good high, adapter off, and loads the default timing registers.
// A stalled result holds the input stage; the input stage still takes a new
// beat while the result register is full as long as it is itself empty.
module board_power_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  bps_pkg::in_item_t            item_data,
	output logic                         result_valid,
	input  logic                         result_ready,
	output bps_pkg::out_item_t           result_data,
	input  logic                         cfg_we,
	input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bps_pkg::MsW-1:0]      cfg_data
);

	bps_pkg::cfg_t      cfg;
	bps_pkg::in_item_t  item_s1;
	logic               valid_s1;
	bps_pkg::out_item_t res_nxt;
	bps_pkg::out_item_t result_q;
	logic               result_valid_q;
	logic               advance;
	logic               core_busy;

	bps_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	// Step the sequencer when the input stage holds a beat and the result
	// register is free or draining this cycle.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item_data;
		end
	end

	bps_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.item   (item_s1),
		.cfg    (cfg),
		.nxt    (res_nxt),
		.busy   (core_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	// Every step produces exactly one result beat.
	a_step_makes_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("step did not load the result register");

	// The input stage only blocks while it holds a beat behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && result_valid_q && !result_ready))
		else $error("input stage stalled without a stalled result");

	// A byte that arrives mid-sequence is ignored, so busy stays set.
	a_byte_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == bps_pkg::KIND_BYTE && core_busy) |=> result_q.busy_res)
		else $error("byte received while busy changed the sequence");

endmodule
